>>> hdl/pbsd_pkg.sv
// ----------------------------------------------------------------------------
// pbsd_pkg: shared types and constants for the paletted block state decoder
// Holds the command and result formats, configuration bundle and the small
// tables that map a field width to fields per word and its reciprocal.
// ----------------------------------------------------------------------------
package pbsd_pkg;

    // Input item kinds
    localparam logic [1:0] KIND_LOAD_PAL  = 2'd0;
    localparam logic [1:0] KIND_LOAD_WORD = 2'd1;
    localparam logic [1:0] KIND_DECODE    = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_PALETTE_SIZE  = 2'd0;
    localparam logic [1:0] CFG_WORD_COUNT    = 2'd1;
    localparam logic [1:0] CFG_SECTION_INDEX = 2'd2;

    localparam int CFG_DATA_W  = 13;
    localparam int FIELD_W     = 13;     // widest palette index field
    localparam int WORD_BITS   = 64;
    localparam int WI_W        = 10;     // word index width
    localparam int RECIP_SHIFT = 16;     // reciprocal scale for slot / per
    localparam int CMD_DEPTH   = 4;
    localparam int OUT_DEPTH   = 4;
    localparam int OUT_CW      = $clog2(OUT_DEPTH + 1);
    localparam logic [9:0] Y_OFFSET = 10'd64;

    typedef enum logic [2:0] {
        OP_LOAD_PAL,
        OP_LOAD_WORD,
        OP_DEC_UNIFORM,
        OP_DEC_MISSING,
        OP_DEC_READ
    } t_op;

    typedef struct packed {
        logic [12:0] palette_size;
        logic [10:0] word_count;
        logic [4:0]  section_index;
        logic [3:0]  width;
        logic [4:0]  per;
        logic [14:0] recip;
    } t_cfg;

    typedef struct packed {
        logic [3:0] pos_x;
        logic [3:0] pos_z;
        logic [9:0] world_y;
    } t_pos;

    typedef struct packed {
        t_op             op;
        logic [11:0]     wr_addr;
        logic [63:0]     wr_data;
        logic [WI_W-1:0] lo_addr;
        logic [WI_W-1:0] hi_addr;
        logic            lo_ok;
        logic            hi_ok;
        logic [5:0]      sh;
        t_pos            pos;
    } t_cmd;

    typedef struct packed {
        logic [31:0] state_id;
        t_pos        pos;
        logic        replaced;
        logic        missing;
    } t_result;

    // ceil(log2(size)), at least 4
    function automatic logic [3:0] f_width(input logic [12:0] size);
        logic [12:0] v;
        logic [3:0]  bits;
        v    = size - 13'd1;
        bits = 4'd0;
        for (int i = 0; i < 13; i++) begin
            if (v[i]) begin
                bits = 4'(i + 1);
            end
        end
        if (size <= 13'd1 || bits < 4'd4) begin
            bits = 4'd4;
        end
        return bits;
    endfunction

    // fields per padded word
    function automatic logic [4:0] f_per(input logic [3:0] width);
        logic [4:0] per;
        case (width)
            4'd4:    per = 5'd16;
            4'd5:    per = 5'd12;
            4'd6:    per = 5'd10;
            4'd7:    per = 5'd9;
            4'd8:    per = 5'd8;
            4'd9:    per = 5'd7;
            4'd10:   per = 5'd6;
            4'd11:   per = 5'd5;
            4'd12:   per = 5'd5;
            4'd13:   per = 5'd4;
            default: per = 5'd16;
        endcase
        return per;
    endfunction

    // ceil(2^16 / per); exact quotient for any 12-bit slot
    function automatic logic [14:0] f_recip(input logic [3:0] width);
        logic [14:0] r;
        case (width)
            4'd4:    r = 15'd4096;
            4'd5:    r = 15'd5462;
            4'd6:    r = 15'd6554;
            4'd7:    r = 15'd7282;
            4'd8:    r = 15'd8192;
            4'd9:    r = 15'd9363;
            4'd10:   r = 15'd10923;
            4'd11:   r = 15'd13108;
            4'd12:   r = 15'd13108;
            4'd13:   r = 15'd16384;
            default: r = 15'd4096;
        endcase
        return r;
    endfunction

endpackage

>>> hdl/paletted_block_state_decoder_core.sv
// ----------------------------------------------------------------------------
// paletted_block_state_decoder_core: packed palette index section decoder
// Decodes pass the front end, command queue, stages A and B and result queue.
// Throughput: one item per cycle if not stalled, set by the two-read-port
// word store and one palette read per cycle; loads give no result.
// Reset: synchronous, active low; clears queues and pipeline valids and sets
// palette_size 1, word_count 0, section_index 0. Stores are not cleared.
// ----------------------------------------------------------------------------
module paletted_block_state_decoder_core #(
    parameter int PALETTE_DEPTH = 4096,
    parameter int WORD_DEPTH    = 1024,
    parameter int SECTION_COUNT = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [1:0]                      i_cfg_index,
    input  logic [pbsd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input queue side
    input  logic                            push,
    output logic                            full,
    input  logic [1:0]                      i_kind,
    input  logic [11:0]                     i_slot,
    input  logic [31:0]                     i_palette_value,
    input  logic [63:0]                     i_data_word,
    // result queue side
    output logic                            empty,
    input  logic                            pop,
    output logic [31:0]                     o_state_id,
    output logic [3:0]                      o_pos_x,
    output logic [3:0]                      o_pos_z,
    output logic signed [9:0]               o_world_y,
    output logic                            o_index_replaced,
    output logic                            o_data_missing
);
    localparam int CMD_W = $bits(pbsd_pkg::t_cmd);
    localparam int RES_W = $bits(pbsd_pkg::t_result);

    // configuration registers; the width and its padded-layout helpers are
    // derived once at write time so the datapath sees them as plain flops
    logic [12:0] r_palette_size;
    logic [10:0] r_word_count;
    logic [4:0]  r_section_index;
    logic [3:0]  r_width;
    logic [4:0]  r_per;
    logic [14:0] r_recip;
    logic [3:0]  n_width;
    logic        cfg_wr;

    pbsd_pkg::t_cfg    cfg;
    pbsd_pkg::t_cmd    cmd_in;
    pbsd_pkg::t_cmd    cmd_out;
    logic [CMD_W-1:0]  cmd_out_bits;
    logic              cmd_push;
    logic              cmd_pop;
    logic              cmd_empty;
    logic              cmd_full;
    logic [$clog2(pbsd_pkg::CMD_DEPTH+1)-1:0] cmd_count;

    pbsd_pkg::t_result res_in;
    pbsd_pkg::t_result res_out;
    logic [RES_W-1:0]  res_out_bits;
    logic              res_push;
    logic              res_full;
    logic [pbsd_pkg::OUT_CW-1:0] res_count;

    // every write is taken at once
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign n_width     = pbsd_pkg::f_width(i_cfg_data[12:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_palette_size  <= 13'd1;
            r_word_count    <= 11'd0;
            r_section_index <= 5'd0;
            r_width         <= 4'd4;
            r_per           <= 5'd16;
            r_recip         <= 15'd4096;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                pbsd_pkg::CFG_PALETTE_SIZE: begin
                    r_palette_size <= i_cfg_data[12:0];
                    r_width        <= n_width;
                    r_per          <= pbsd_pkg::f_per(n_width);
                    r_recip        <= pbsd_pkg::f_recip(n_width);
                end
                pbsd_pkg::CFG_WORD_COUNT: begin
                    r_word_count <= i_cfg_data[10:0];
                end
                pbsd_pkg::CFG_SECTION_INDEX: begin
                    r_section_index <= i_cfg_data[4:0];
                end
                default: begin
                    // unknown index: drop the transfer
                end
            endcase
        end
    end

    always_comb begin
        cfg.palette_size  = r_palette_size;
        cfg.word_count    = r_word_count;
        cfg.section_index = r_section_index;
        cfg.width         = r_width;
        cfg.per           = r_per;
        cfg.recip         = r_recip;
    end

    // front end: capture, classify and address each item
    pbsd_front #(
        .PALETTE_DEPTH (PALETTE_DEPTH),
        .WORD_DEPTH    (WORD_DEPTH),
        .SECTION_COUNT (SECTION_COUNT)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_push          (push),
        .o_full          (full),
        .i_kind          (i_kind),
        .i_slot          (i_slot),
        .i_palette_value (i_palette_value),
        .i_data_word     (i_data_word),
        .o_cmd_push      (cmd_push),
        .o_cmd           (cmd_in),
        .i_cmd_full      (cmd_full)
    );

    // command queue decouples address generation from store access
    pbsd_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (pbsd_pkg::CMD_DEPTH)
    ) u_cmd_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (cmd_push),
        .i_wr_data (cmd_in),
        .i_rd      (cmd_pop),
        .o_rd_data (cmd_out_bits),
        .o_empty   (cmd_empty),
        .o_full    (cmd_full),
        .o_count   (cmd_count)
    );

    assign cmd_out = pbsd_pkg::t_cmd'(cmd_out_bits);

    // back end: stores, index extraction and palette lookup; it issues only
    // while the result queue has room for everything already in flight
    pbsd_back #(
        .PALETTE_DEPTH (PALETTE_DEPTH),
        .WORD_DEPTH    (WORD_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd_empty (cmd_empty || (cmd_count == '0)),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .i_out_count (res_count),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    // result queue; its head drives the result ports
    pbsd_fifo #(
        .WIDTH (RES_W),
        .DEPTH (pbsd_pkg::OUT_DEPTH)
    ) u_res_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (res_push && !res_full),
        .i_wr_data (res_in),
        .i_rd      (pop),
        .o_rd_data (res_out_bits),
        .o_empty   (empty),
        .o_full    (res_full),
        .o_count   (res_count)
    );

    assign res_out          = pbsd_pkg::t_result'(res_out_bits);
    assign o_state_id       = res_out.state_id;
    assign o_pos_x          = res_out.pos.pos_x;
    assign o_pos_z          = res_out.pos.pos_z;
    assign o_world_y        = signed'(res_out.pos.world_y);
    assign o_index_replaced = res_out.replaced;
    assign o_data_missing   = res_out.missing;
endmodule

>>> hdl/pbsd_fifo.sv
// ----------------------------------------------------------------------------
// pbsd_fifo: small register queue
// First-word-fall-through queue with occupancy count.
// ----------------------------------------------------------------------------
module pbsd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_wr,
    input  logic [WIDTH-1:0]             i_wr_data,
    input  logic                         i_rd,
    output logic [WIDTH-1:0]             o_rd_data,
    output logic                         o_empty,
    output logic                         o_full,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_wr;
    logic             do_rd;

    assign o_empty   = (r_count == '0);
    assign o_full    = (r_count == CW'(DEPTH));
    assign o_count   = r_count;
    assign o_rd_data = r_mem[r_rd_ptr];
    assign do_wr     = i_wr && !o_full;
    assign do_rd     = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + CW'(1);
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - CW'(1);
            end
        end
    end
endmodule

>>> hdl/pbsd_front.sv
// ----------------------------------------------------------------------------
// pbsd_front: accept and classify input items
// Captures an item, works out word addresses and bit offset of its palette
// index, and issues a command to the back end; dead items are dropped.
// ----------------------------------------------------------------------------
module pbsd_front #(
    parameter int PALETTE_DEPTH = 4096,
    parameter int WORD_DEPTH    = 1024,
    parameter int SECTION_COUNT = 24
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pbsd_pkg::t_cfg   i_cfg,
    input  logic             i_push,
    output logic             o_full,
    input  logic [1:0]       i_kind,
    input  logic [11:0]      i_slot,
    input  logic [31:0]      i_palette_value,
    input  logic [63:0]      i_data_word,
    output logic             o_cmd_push,
    output pbsd_pkg::t_cmd   o_cmd,
    input  logic             i_cmd_full
);
    logic                      r_valid;
    logic [1:0]                r_kind;
    logic [11:0]               r_slot;
    logic [63:0]               r_data;
    logic [pbsd_pkg::WI_W-1:0] r_q;
    logic [15:0]               r_bitpos;

    logic                      accept;
    logic                      drain;
    logic                      need;
    pbsd_pkg::t_op             op;
    logic [26:0]               prod;
    logic [15:0]               bitpos;
    logic                      contig;
    logic [7:0]                qp;
    logic [3:0]                rem;
    logic [7:0]                shp;
    logic [pbsd_pkg::WI_W-1:0] wi;
    logic [10:0]               wi1;
    logic [5:0]                sh;
    logic                      spill;
    logic                      lo_ok;
    logic                      hi_ok;

    assign accept = i_push && !o_full;
    assign prod   = 27'(i_slot) * 27'(i_cfg.recip);
    assign bitpos = 16'(i_slot) * 16'(i_cfg.width);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (drain) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind   <= i_kind;
            r_slot   <= i_slot;
            r_data   <= (i_kind == pbsd_pkg::KIND_LOAD_PAL) ?
                        {32'd0, i_palette_value} : i_data_word;
            r_q      <= prod[pbsd_pkg::RECIP_SHIFT +: pbsd_pkg::WI_W];
            r_bitpos <= bitpos;
        end
    end

    // word index and bit offset for both layouts
    always_comb begin
        contig = (i_cfg.word_count == {1'b0, i_cfg.width, 6'd0});
        qp     = {4'd0, r_q[3:0]} * {4'd0, i_cfg.per[3:0]};
        rem    = r_slot[3:0] - qp[3:0];
        shp    = {4'd0, rem} * {4'd0, i_cfg.width};
        wi     = contig ? r_bitpos[15:6] : r_q;
        sh     = contig ? r_bitpos[5:0] : shp[5:0];
        wi1    = {1'b0, wi} + 11'd1;
        spill  = ({1'b0, sh} + {3'd0, i_cfg.width}) > 7'(pbsd_pkg::WORD_BITS);
        lo_ok  = ({1'b0, wi} < i_cfg.word_count) && ({1'b0, wi} < 11'(WORD_DEPTH));
        hi_ok  = contig && spill && (wi1 < i_cfg.word_count) && (wi1 < 11'(WORD_DEPTH));
    end

    always_comb begin
        need = 1'b0;
        op   = pbsd_pkg::OP_LOAD_PAL;
        case (r_kind)
            pbsd_pkg::KIND_LOAD_PAL: begin
                need = ({1'b0, r_slot} < 13'(PALETTE_DEPTH));
                op   = pbsd_pkg::OP_LOAD_PAL;
            end
            pbsd_pkg::KIND_LOAD_WORD: begin
                need = ({1'b0, r_slot} < 13'(WORD_DEPTH));
                op   = pbsd_pkg::OP_LOAD_WORD;
            end
            pbsd_pkg::KIND_DECODE: begin
                need = ({2'd0, i_cfg.section_index} < 7'(SECTION_COUNT));
                if (i_cfg.palette_size <= 13'd1) begin
                    op = pbsd_pkg::OP_DEC_UNIFORM;
                end else if (i_cfg.word_count == 11'd0) begin
                    op = pbsd_pkg::OP_DEC_MISSING;
                end else begin
                    op = pbsd_pkg::OP_DEC_READ;
                end
            end
            default: begin
                need = 1'b0;
            end
        endcase
    end

    assign drain      = r_valid && (!need || !i_cmd_full);
    assign o_full     = r_valid && !drain;
    assign o_cmd_push = r_valid && need && !i_cmd_full;

    always_comb begin
        o_cmd.op          = op;
        o_cmd.wr_addr     = r_slot;
        o_cmd.wr_data     = r_data;
        o_cmd.lo_addr     = wi;
        o_cmd.hi_addr     = wi1[pbsd_pkg::WI_W-1:0];
        o_cmd.lo_ok       = lo_ok;
        o_cmd.hi_ok       = hi_ok;
        o_cmd.sh          = sh;
        o_cmd.pos.pos_x   = r_slot[3:0];
        o_cmd.pos.pos_z   = r_slot[7:4];
        o_cmd.pos.world_y = 10'({i_cfg.section_index, 4'd0}) + 10'(r_slot[11:8])
                            - pbsd_pkg::Y_OFFSET;
    end
endmodule

>>> hdl/pbsd_back.sv
// ----------------------------------------------------------------------------
// pbsd_back: execute commands against the palette and word stores
// Stage A reads up to two words, stage B extracts the index and reads the
// palette, then the result goes to the output queue.
// ----------------------------------------------------------------------------
module pbsd_back #(
    parameter int PALETTE_DEPTH = 4096,
    parameter int WORD_DEPTH    = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pbsd_pkg::t_cfg              i_cfg,
    input  logic                        i_cmd_empty,
    input  pbsd_pkg::t_cmd              i_cmd,
    output logic                        o_cmd_pop,
    input  logic [pbsd_pkg::OUT_CW-1:0] i_out_count,
    output logic                        o_res_push,
    output pbsd_pkg::t_result           o_res
);
    localparam int PA = $clog2(PALETTE_DEPTH);
    localparam int WA = $clog2(WORD_DEPTH);
    localparam int FW = pbsd_pkg::FIELD_W;

    logic [63:0] r_word_mem [WORD_DEPTH];
    logic [31:0] r_pal_mem  [PALETTE_DEPTH];

    logic                      r_a_valid;
    pbsd_pkg::t_op             r_a_op;
    logic [5:0]                r_a_sh;
    logic                      r_a_lo_ok;
    logic                      r_a_hi_ok;
    pbsd_pkg::t_pos            r_a_pos;
    logic [63:0]               r_lo;
    logic [63:0]               r_hi;

    logic                      r_b_valid;
    logic                      r_b_use_pal;
    logic                      r_b_replaced;
    logic                      r_b_missing;
    pbsd_pkg::t_pos            r_b_pos;
    logic [31:0]               r_pal_rd;

    logic                      launch;
    logic                      is_dec;
    logic [3:0]                in_flight;
    logic [63:0]               lo;
    logic [63:0]               hi;
    logic [FW+63:0]            win;
    logic [FW-1:0]             mask;
    logic [FW-1:0]             field;
    logic                      replaced;
    logic [FW-1:0]             p_use;
    logic                      pal_ok;
    logic                      use_pal;
    logic [PA-1:0]             rd_idx;

    // hold issue while the output queue could overflow
    assign in_flight = 4'(i_out_count) + 4'(r_a_valid) + 4'(r_b_valid);
    assign launch    = !i_cmd_empty && (in_flight < 4'(pbsd_pkg::OUT_DEPTH));
    assign o_cmd_pop = launch;
    assign is_dec    = i_cmd.op inside {pbsd_pkg::OP_DEC_UNIFORM, pbsd_pkg::OP_DEC_MISSING,
                                        pbsd_pkg::OP_DEC_READ};

    always_ff @(posedge i_clk) begin
        if (launch && i_cmd.op == pbsd_pkg::OP_LOAD_WORD) begin
            r_word_mem[i_cmd.wr_addr[WA-1:0]] <= i_cmd.wr_data;
        end
        if (launch) begin
            r_lo <= r_word_mem[i_cmd.lo_addr[WA-1:0]];
            r_hi <= r_word_mem[i_cmd.hi_addr[WA-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (launch && i_cmd.op == pbsd_pkg::OP_LOAD_PAL) begin
            r_pal_mem[i_cmd.wr_addr[PA-1:0]] <= i_cmd.wr_data[31:0];
        end
        if (r_a_valid) begin
            r_pal_rd <= r_pal_mem[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= launch && is_dec;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (launch) begin
            r_a_op    <= i_cmd.op;
            r_a_sh    <= i_cmd.sh;
            r_a_lo_ok <= i_cmd.lo_ok;
            r_a_hi_ok <= i_cmd.hi_ok;
            r_a_pos   <= i_cmd.pos;
        end
        if (r_a_valid) begin
            r_b_use_pal  <= use_pal;
            r_b_replaced <= replaced;
            r_b_missing  <= (r_a_op == pbsd_pkg::OP_DEC_MISSING);
            r_b_pos      <= r_a_pos;
        end
    end

    // extract the palette index; words past the loaded count read as zero
    always_comb begin
        lo       = r_a_lo_ok ? r_lo : 64'd0;
        hi       = r_a_hi_ok ? r_hi : 64'd0;
        win      = {hi[FW-1:0], lo} >> r_a_sh;
        mask     = ~({FW{1'b1}} << i_cfg.width);
        field    = win[FW-1:0] & mask;
        replaced = (r_a_op == pbsd_pkg::OP_DEC_READ) && (field >= i_cfg.palette_size);
        p_use    = replaced ? '0 : field;
        pal_ok   = (p_use < FW'(PALETTE_DEPTH));
        rd_idx   = (r_a_op == pbsd_pkg::OP_DEC_READ) ? p_use[PA-1:0] : '0;
        use_pal  = (r_a_op == pbsd_pkg::OP_DEC_UNIFORM) ||
                   ((r_a_op == pbsd_pkg::OP_DEC_READ) && pal_ok);
    end

    assign o_res_push     = r_b_valid;
    assign o_res.state_id = r_b_use_pal ? r_pal_rd : 32'd0;
    assign o_res.pos      = r_b_pos;
    assign o_res.replaced = r_b_replaced;
    assign o_res.missing  = r_b_missing;
endmodule

>>> tb/tb_paletted_block_state_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_paletted_block_state_decoder_core: self-checking bench for the decoder
// Fills the palette and word stores and steps the registers through the
// packing layouts: uniform palette, missing data, bitstream, padded words,
// palettes wider than the store and sections out of range. A scoreboard keeps
// its own copy of both stores and registers and checks every decoded block,
// field by field, while both queue sides stall at random.
// ----------------------------------------------------------------------------
module tb_paletted_block_state_decoder_core;
    import pbsd_pkg::*;

    localparam int PALETTE_DEPTH = 4096;
    localparam int WORD_DEPTH    = 1024;
    localparam int SECTION_COUNT = 24;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 300;    // receiver hold-off, long enough to fill both queues
    localparam int RANDOM_PHASES = 15;
    localparam int PHASE_ITEMS   = 60;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the stores and registers, predicts each decoded
    // block and holds the predictions until the block pops them.
    // ------------------------------------------------------------------------
    class block_state_board;
        bit [31:0] palette_mem [PALETTE_DEPTH];
        bit [63:0] word_mem [WORD_DEPTH];
        bit [12:0] palette_size = 13'd1;
        bit [10:0] word_count;
        bit [4:0]  section_index;
        t_result   expected_blocks [$];
        int        errors;
        int        checked;
        int        replaced_seen;
        int        missing_seen;

        // ceil(log2(size)), never below 4
        function int unsigned field_width(bit [12:0] size);
            bit [12:0]   v = size - 13'd1;
            int unsigned bits = 0;
            if (size > 13'd1) begin
                while (v != 13'd0) begin
                    bits++;
                    v = v >> 1;
                end
            end
            return (bits < 4) ? 4 : bits;
        endfunction

        // words past the loaded count or past the store read as zero
        function bit [63:0] stored_word(int unsigned wi);
            if (wi >= word_count || wi >= WORD_DEPTH) begin
                return 64'd0;
            end
            return word_mem[wi];
        endfunction

        function int unsigned palette_index(bit [11:0] idx, int unsigned w);
            bit [63:0]   mask = (64'd1 << w) - 64'd1;
            bit [63:0]   v;
            int unsigned bit_pos;
            int unsigned wi;
            int unsigned sh;
            int unsigned per;
            if (word_count == 64 * w) begin
                // one continuous stream, LSB first; a field may straddle two words
                bit_pos = idx * w;
                wi      = bit_pos >> 6;
                sh      = bit_pos & 63;
                v       = stored_word(wi) >> sh;
                if (sh + w > 64) begin
                    v |= stored_word(wi + 1) << (64 - sh);
                end
            end else begin
                // whole fields per word, padding at the top
                per = 64 / w;
                wi  = idx / per;
                sh  = (idx % per) * w;
                v   = stored_word(wi) >> sh;
            end
            return 32'(v & mask);
        endfunction

        function t_result predict_block(bit [11:0] slot);
            t_result     r;
            int unsigned p;
            int          y;
            r = '0;
            if (palette_size <= 13'd1) begin
                r.state_id = palette_mem[0];
            end else if (word_count == 11'd0) begin
                r.missing = 1'b1;
            end else begin
                p = palette_index(slot, field_width(palette_size));
                if (p >= palette_size) begin
                    p          = 0;
                    r.replaced = 1'b1;
                end
                r.state_id = (p < PALETTE_DEPTH) ? palette_mem[p] : 32'd0;
            end
            y               = int'(section_index) * 16 + int'(slot[11:8]) - 64;
            r.pos.pos_x     = slot[3:0];
            r.pos.pos_z     = slot[7:4];
            r.pos.world_y   = y[9:0];
            return r;
        endfunction

        function void write_register(logic [1:0] index, logic [12:0] value);
            case (index)
                CFG_PALETTE_SIZE:  palette_size  = value;
                CFG_WORD_COUNT:    word_count    = value[10:0];
                CFG_SECTION_INDEX: section_index = value[4:0];
                default: ;
            endcase
        endfunction

        // note one accepted input transfer
        function void note_item(logic [1:0] kind, logic [11:0] slot,
                                logic [31:0] pal_value, logic [63:0] word);
            case (kind)
                KIND_LOAD_PAL: begin
                    palette_mem[slot] = pal_value;
                end
                KIND_LOAD_WORD: begin
                    if (slot < WORD_DEPTH) begin
                        word_mem[slot] = word;
                    end
                end
                KIND_DECODE: begin
                    if (section_index < SECTION_COUNT) begin
                        expected_blocks.push_back(predict_block(slot));
                    end
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            end
        endfunction

        // check one accepted result transfer against the oldest prediction
        function void check_block(logic [31:0] state_id, logic [3:0] pos_x,
                                  logic [3:0] pos_z, logic [9:0] world_y,
                                  logic replaced, logic missing);
            t_result e;
            if (expected_blocks.size() == 0) begin
                errors++;
                $error("unexpected block: state_id 0x%0h x %0d z %0d",
                       state_id, pos_x, pos_z);
                return;
            end
            e = expected_blocks.pop_front();
            checked++;
            replaced_seen += e.replaced;
            missing_seen  += e.missing;
            compare_field("state_id", e.state_id, state_id);
            compare_field("pos_x", e.pos.pos_x, pos_x);
            compare_field("pos_z", e.pos.pos_z, pos_z);
            compare_field("world_y", e.pos.world_y, world_y);
            compare_field("index_replaced", e.replaced, replaced);
            compare_field("data_missing", e.missing, missing);
        endfunction

        function int pending();
            return expected_blocks.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and the block under test
    // ------------------------------------------------------------------------
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [1:0]            i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  push;
    logic                  full;
    logic [1:0]            i_kind;
    logic [11:0]           i_slot;
    logic [31:0]           i_palette_value;
    logic [63:0]           i_data_word;
    logic                  empty;
    logic                  pop;
    logic [31:0]           o_state_id;
    logic [3:0]            o_pos_x;
    logic [3:0]            o_pos_z;
    logic signed [9:0]     o_world_y;
    logic                  o_index_replaced;
    logic                  o_data_missing;

    block_state_board board;

    // which store entries hold a value; decodes must never reach any other
    bit          pal_loaded [PALETTE_DEPTH];
    bit          word_loaded [WORD_DEPTH];
    bit          idling_on;
    bit          long_hold_req;
    int unsigned cycle_count;
    int          items_sent;
    int          input_stalls;
    int          phases_run;

    paletted_block_state_decoder_core uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .push             (push),
        .full             (full),
        .i_kind           (i_kind),
        .i_slot           (i_slot),
        .i_palette_value  (i_palette_value),
        .i_data_word      (i_data_word),
        .empty            (empty),
        .pop              (pop),
        .o_state_id       (o_state_id),
        .o_pos_x          (o_pos_x),
        .o_pos_z          (o_pos_z),
        .o_world_y        (o_world_y),
        .o_index_replaced (o_index_replaced),
        .o_data_missing   (o_data_missing)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: end the run if it hangs.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d blocks still expected",
                 cycle_count, board.pending());
        $display("[paletted_block_state_decoder_core] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Monitor: sample pre-edge values, so every transfer is seen exactly once
    // regardless of the order of processes within the edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                board.write_register(i_cfg_index, i_cfg_data);
            end
            if (push && !full) begin
                board.note_item(i_kind, i_slot, i_palette_value, i_data_word);
            end
            if (push && full) begin
                input_stalls++;
            end
            if (pop && !empty) begin
                board.check_block(o_state_id, o_pos_x, o_pos_z, o_world_y,
                                  o_index_replaced, o_data_missing);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: pop, with stall bursts of random length; on request,
    // hold off for a long stretch so the block backs up into its input.
    // ------------------------------------------------------------------------
    initial begin
        int hold_left;
        hold_left = 0;
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                pop <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge i_clk);
                long_hold_req = 1'b0;
            end else if (hold_left > 0) begin
                pop <= 1'b0;
                hold_left--;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                pop <= 1'b0;
                hold_left = $urandom_range(0, 3);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks, each entered at a rising edge; send_item returns at the edge
    // of its transfer; push stays high so back-to-back items need no gap.
    // ------------------------------------------------------------------------
    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    task automatic send_item(input logic [1:0] kind, input logic [11:0] slot,
                             input logic [31:0] pal_value, input logic [63:0] word);
        int gap;
        gap = 0;
        if (idling_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 4);
        end
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push            <= 1'b1;
        i_kind          <= kind;
        i_slot          <= slot;
        i_palette_value <= pal_value;
        i_data_word     <= word;
        // hold until the block takes the transfer
        do @(posedge i_clk); while (full);
        if (kind == KIND_LOAD_PAL) begin
            pal_loaded[slot] = 1'b1;
        end
        if (kind == KIND_LOAD_WORD && slot < WORD_DEPTH) begin
            word_loaded[slot] = 1'b1;
        end
        items_sent++;
    endtask

    task automatic write_config(input logic [1:0] index, input logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drop push, wait for every expected block, then let loads still in the
    // pipeline retire before anything touches the registers.
    task automatic settle_block();
        push <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly decodes over the whole section, with rewrites of both stores,
    // loads that fall past the word store and the unused kind mixed in.
    task automatic random_item();
        int          pick;
        logic [11:0] slot;
        pick = $urandom_range(0, 99);
        slot = 12'($urandom_range(0, 4095));
        if (pick < 80) begin
            send_item(KIND_DECODE, slot, $urandom, rand_word());
        end else if (pick < 89) begin
            send_item(KIND_LOAD_PAL, slot, $urandom, rand_word());
        end else if (pick < 97) begin
            if ($urandom_range(0, 1) == 0) begin
                slot = 12'($urandom_range(0, WORD_DEPTH - 1));
            end
            send_item(KIND_LOAD_WORD, slot, $urandom, rand_word());
        end else begin
            send_item(KIND_UNUSED, slot, $urandom, rand_word());
        end
    endtask

    // One register setting: program all three registers while idle, back
    // every store entry the layout can reach, hit the corner slots, then
    // run the random items and drain.
    task automatic run_phase(input logic [12:0] pal_size, input logic [10:0] words,
                             input logic [4:0] section, input int extra);
        int pal_need;
        int word_need;
        pal_need  = (pal_size > PALETTE_DEPTH) ? PALETTE_DEPTH : int'(pal_size);
        pal_need  = (pal_need < 1) ? 1 : pal_need;
        word_need = (words > WORD_DEPTH) ? WORD_DEPTH : int'(words);
        write_config(CFG_PALETTE_SIZE, pal_size);
        write_config(CFG_WORD_COUNT, 13'(words));
        write_config(CFG_SECTION_INDEX, 13'(section));
        for (int s = 0; s < pal_need; s++) begin
            if (!pal_loaded[s]) begin
                send_item(KIND_LOAD_PAL, 12'(s), $urandom, rand_word());
            end
        end
        for (int s = 0; s < word_need; s++) begin
            if (!word_loaded[s]) begin
                send_item(KIND_LOAD_WORD, 12'(s), $urandom, rand_word());
            end
        end
        // first and last block, plus one that straddles a word in a 5-bit stream
        send_item(KIND_DECODE, 12'd0, $urandom, rand_word());
        send_item(KIND_DECODE, 12'hFFF, $urandom, rand_word());
        send_item(KIND_DECODE, 12'd12, $urandom, rand_word());
        repeat (extra) random_item();
        settle_block();
        phases_run++;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [12:0] ps;
        logic [10:0] wc;
        logic [4:0]  sec;
        int unsigned w;

        board           = new;
        i_rst_n         <= 1'b0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= CFG_PALETTE_SIZE;
        i_cfg_data      <= '0;
        push            <= 1'b0;
        i_kind          <= KIND_LOAD_PAL;
        i_slot          <= '0;
        i_palette_value <= '0;
        i_data_word     <= '0;
        idling_on       = 1'b1;
        long_hold_req   = 1'b0;
        items_sent      = 0;
        input_stalls    = 0;
        phases_run      = 0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values: a one-entry palette needs no words. Also push the
        // unused kind and a word load past the store, both dropped.
        send_item(KIND_LOAD_PAL, 12'd0, $urandom, rand_word());
        send_item(KIND_DECODE, 12'hFFF, $urandom, rand_word());
        send_item(KIND_UNUSED, 12'hFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(KIND_LOAD_WORD, 12'hFFF, 32'd0, rand_word());
        settle_block();

        // Directed settings
        run_phase(13'd0,    11'd0,    5'd23, 0);  // empty palette acts as uniform; y up to 319
        run_phase(13'd2,    11'd0,    5'd0,  0);  // data missing
        run_phase(13'd16,   11'd256,  5'd1,  0);  // 4-bit stream
        run_phase(13'd20,   11'd320,  5'd2,  0);  // 5-bit stream: straddles, replaced index
        run_phase(13'd16,   11'd10,   5'd3,  0);  // padded, blocks past loaded words read 0
        run_phase(13'd8191, 11'd832,  5'd4,  0);  // widest field, indexes past the palette store
        run_phase(13'd4096, 11'd2047, 5'd22, 0);  // padded 12-bit, count past the word store
        run_phase(13'd3,    11'd5,    5'd24, 0);  // section out of range, no blocks come back

        // Random settings
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case ($urandom_range(0, 9))
                0:       ps = 13'($urandom_range(0, 1));
                1:       ps = 13'($urandom_range(4097, 8191));
                2, 3:    ps = 13'($urandom_range(17, 4096));
                default: ps = 13'($urandom_range(2, 300));
            endcase
            w = board.field_width(ps);
            case ($urandom_range(0, 7))
                0:       wc = 11'd0;
                1, 2:    wc = 11'($urandom_range(1, 2047));
                default: wc = 11'(64 * w);
            endcase
            sec = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(24, 31))
                                              : 5'($urandom_range(0, 23));
            // back up the block: receiver holds off while decodes keep coming
            if (p == 2) begin
                long_hold_req = 1'b1;
            end
            // finish with a stretch of full-rate traffic on both sides
            if (p == RANDOM_PHASES - 3) begin
                idling_on = 1'b0;
            end
            run_phase(ps, wc, sec, PHASE_ITEMS);
        end

        $display("covered %0d items over %0d register settings, %0d blocks checked",
                 items_sent, phases_run, board.checked);
        $display("index replaced on %0d blocks, data missing on %0d, input held %0d cycles",
                 board.replaced_seen, board.missing_seen, input_stalls);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("[paletted_block_state_decoder_core] OK");
        end else begin
            $display("[paletted_block_state_decoder_core] ERROR");
        end
        $finish;
    end

endmodule
